### src/ntl_pkg.sv
// types and constants shared by the nearest timestamp lookup
// no dependencies
`timescale 1ns / 1ps

package ntl_pkg;

    localparam int KEY_W   = 48;
    localparam int TAG_W   = 16;
    localparam int TOL_W   = 32;
    localparam int CNT_W   = 11;
    localparam int OP_W    = 2;
    localparam int STAT_W  = 2;

    // operation codes
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

    // status codes
    localparam logic [STAT_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_NO_MATCH = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_FULL     = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]  operation;
        logic [KEY_W-1:0] key_time;
        logic [TAG_W-1:0] entry_tag;
    } t_req;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [TAG_W-1:0]  match_tag;
        logic [KEY_W-1:0]  abs_difference;
        logic [CNT_W-1:0]  entry_count;
    } t_rsp;

    // one table entry as held in memory
    typedef struct packed {
        logic [KEY_W-1:0] key_us;
        logic [TAG_W-1:0] tag;
    } t_entry;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SRCH,
        ST_SRCH_WT,
        ST_SHIFT,
        ST_Q_RDA,
        ST_Q_RDB,
        ST_Q_CMP,
        ST_Q_SEL,
        ST_RESP
    } t_state;

endpackage

### src/nearest_timestamp_lookup.sv
// nearest timestamp lookup over a sorted table held in one synchronous memory
// depends on ntl_pkg
`timescale 1ns / 1ps

// The block holds up to TABLE_DEPTH (time, tag) entries in ascending time order
// in a single-port-read / single-port-write memory with a registered read.
// A request carries an operation: clear, insert or query. Clear, an insert into a
// full table, a query of an empty table and the unused operation code go from idle
// straight to the response state, which loads the output register once it is free.
// Insert and query first run a binary search over the filled part of the table,
// each halving issuing a read and then comparing the registered data. Insert then
// moves every entry above the insert point up by one place, one entry per cycle
// through the memory read/write ports, and writes the new entry. Query then reads
// the entry at the search point and the one below it, works out both distances and
// picks the nearer, checked against the tolerance. Every request is taken in idle.
// A new request is taken as soon as the previous one has been handed to the
// output register, even if that response has not yet been taken downstream.
// The tolerance register may be written at any time the block is idle; the
// table needs no clearing pass after reset, since only entries below the fill
// count are ever used.
module nearest_timestamp_lookup
    import ntl_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // request channel
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  t_req                i_in_req,
    // response channel
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output t_rsp                o_out_rsp,
    // tolerance register write
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [TOL_W-1:0]    i_cfg_data
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    // table storage
    t_entry mem [TABLE_DEPTH];
    t_entry r_rd_data;

    logic            mem_we;
    logic [AW-1:0]   mem_wa;
    t_entry          mem_wd;
    logic [AW-1:0]   mem_ra;

    // control state
    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [CW-1:0]   r_lo, n_lo;
    logic [CW-1:0]   r_hi, n_hi;
    logic [CW-1:0]   r_mid, n_mid;
    logic [CW-1:0]   r_idx, n_idx;
    logic            r_wr_pend, n_wr_pend;
    logic [AW-1:0]   r_wr_addr, n_wr_addr;
    logic [TOL_W-1:0] r_tol;

    // request and query working registers
    t_req            r_req, n_req;
    t_entry          r_right, n_right;
    logic            r_have_r, n_have_r;
    logic            r_have_l, n_have_l;
    logic [KEY_W-1:0] r_dr, n_dr;
    logic [KEY_W-1:0] r_dl, n_dl;
    logic [TAG_W-1:0] r_tag_r, n_tag_r;
    logic [TAG_W-1:0] r_tag_l, n_tag_l;

    // pending response (count is attached when it goes out)
    logic [STAT_W-1:0] r_res_status, n_res_status;
    logic [TAG_W-1:0]  r_res_tag, n_res_tag;
    logic [KEY_W-1:0]  r_res_diff, n_res_diff;

    logic            r_out_valid;
    t_rsp            r_out;
    logic            out_load;

    logic            in_fire;
    logic [CW-1:0]   mid_calc;
    logic            is_full;
    logic            take_l;
    logic [KEY_W-1:0] best_d;
    logic            mid_below;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out;

    assign mid_calc = CW'(r_lo + ((r_hi - r_lo) >> 1));
    assign is_full  = (r_count == CW'(TABLE_DEPTH));

    // insert goes after equal keys, query stops at the first key not below
    assign mid_below = (r_req.operation == OP_INSERT) ? (r_rd_data.key_us <= r_req.key_time)
                                                      : (r_rd_data.key_us <  r_req.key_time);

    // earlier neighbour wins only when strictly closer
    assign take_l = r_have_l && (!r_have_r || (r_dl < r_dr));
    assign best_d = take_l ? r_dl : r_dr;

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_mid        = r_mid;
        n_idx        = r_idx;
        n_wr_pend    = r_wr_pend;
        n_wr_addr    = r_wr_addr;
        n_req        = r_req;
        n_right      = r_right;
        n_have_r     = r_have_r;
        n_have_l     = r_have_l;
        n_dr         = r_dr;
        n_dl         = r_dl;
        n_tag_r      = r_tag_r;
        n_tag_l      = r_tag_l;
        n_res_status = r_res_status;
        n_res_tag    = r_res_tag;
        n_res_diff   = r_res_diff;
        mem_we       = 1'b0;
        mem_wa       = '0;
        mem_wd       = '0;
        mem_ra       = '0;
        out_load     = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_req        = i_in_req;
                    n_res_status = STATUS_OK;
                    n_res_tag    = '0;
                    n_res_diff   = '0;
                    n_lo         = '0;
                    n_hi         = r_count;
                    case (i_in_req.operation)
                        OP_CLEAR: begin
                            n_count = '0;
                            n_state = ST_RESP;
                        end
                        OP_INSERT: begin
                            if (is_full) begin
                                n_res_status = STATUS_FULL;
                                n_state      = ST_RESP;
                            end else begin
                                n_state = ST_SRCH;
                            end
                        end
                        OP_QUERY: begin
                            if (r_count == '0) begin
                                n_res_status = STATUS_NO_MATCH;
                                n_state      = ST_RESP;
                            end else begin
                                n_state = ST_SRCH;
                            end
                        end
                        default: begin
                            n_state = ST_RESP;
                        end
                    endcase
                end
            end
            ST_SRCH: begin
                if (r_lo < r_hi) begin
                    mem_ra  = mid_calc[AW-1:0];
                    n_mid   = mid_calc;
                    n_state = ST_SRCH_WT;
                end else if (r_req.operation == OP_INSERT) begin
                    n_idx     = r_count;
                    n_wr_pend = 1'b0;
                    n_state   = ST_SHIFT;
                end else begin
                    n_state = ST_Q_RDA;
                end
            end
            ST_SRCH_WT: begin
                if (mid_below) begin
                    n_lo = CW'(r_mid + 1'b1);
                end else begin
                    n_hi = r_mid;
                end
                n_state = ST_SRCH;
            end
            ST_SHIFT: begin
                // data read last cycle lands one place higher
                if (r_wr_pend) begin
                    mem_we = 1'b1;
                    mem_wa = r_wr_addr;
                    mem_wd = r_rd_data;
                end
                if (r_idx > r_lo) begin
                    mem_ra    = AW'(r_idx - 1'b1);
                    n_wr_pend = 1'b1;
                    n_wr_addr = AW'(r_idx);
                    n_idx     = CW'(r_idx - 1'b1);
                end else begin
                    n_wr_pend = 1'b0;
                    if (!r_wr_pend) begin
                        mem_we  = 1'b1;
                        mem_wa  = AW'(r_lo);
                        mem_wd  = '{key_us: r_req.key_time, tag: r_req.entry_tag};
                        n_count = CW'(r_count + 1'b1);
                        n_state = ST_RESP;
                    end
                end
            end
            ST_Q_RDA: begin
                mem_ra  = AW'(r_lo);
                n_state = ST_Q_RDB;
            end
            ST_Q_RDB: begin
                n_right = r_rd_data;
                mem_ra  = AW'(r_lo - 1'b1);
                n_state = ST_Q_CMP;
            end
            ST_Q_CMP: begin
                n_have_r = (r_lo < r_count);
                n_have_l = (r_lo != '0);
                n_dr     = r_right.key_us - r_req.key_time;
                n_dl     = r_req.key_time - r_rd_data.key_us;
                n_tag_r  = r_right.tag;
                n_tag_l  = r_rd_data.tag;
                n_state  = ST_Q_SEL;
            end
            ST_Q_SEL: begin
                if (best_d > KEY_W'(r_tol)) begin
                    n_res_status = STATUS_NO_MATCH;
                end else begin
                    n_res_status = STATUS_OK;
                    n_res_tag    = take_l ? r_tag_l : r_tag_r;
                    n_res_diff   = best_d;
                end
                n_state = ST_RESP;
            end
            ST_RESP: begin
                if (!r_out_valid || i_out_ready) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_wr_pend   <= 1'b0;
            r_tol       <= TOL_W'(100000);
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_wr_pend <= n_wr_pend;
            if (i_cfg_valid && o_cfg_ready) begin
                r_tol <= i_cfg_data;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_lo         <= n_lo;
        r_hi         <= n_hi;
        r_mid        <= n_mid;
        r_idx        <= n_idx;
        r_wr_addr    <= n_wr_addr;
        r_req        <= n_req;
        r_right      <= n_right;
        r_have_r     <= n_have_r;
        r_have_l     <= n_have_l;
        r_dr         <= n_dr;
        r_dl         <= n_dl;
        r_tag_r      <= n_tag_r;
        r_tag_l      <= n_tag_l;
        r_res_status <= n_res_status;
        r_res_tag    <= n_res_tag;
        r_res_diff   <= n_res_diff;
        if (out_load) begin
            r_out.status         <= r_res_status;
            r_out.match_tag      <= r_res_tag;
            r_out.abs_difference <= r_res_diff;
            r_out.entry_count    <= CNT_W'(r_count);
        end
    end

    // table memory, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rd_data <= mem[mem_ra];
    end

    // fill count never passes the table size
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH))
        else $error("fill count beyond table depth");

    // the table is written only while shifting for an insert
    a_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state == ST_SHIFT) && (r_req.operation == OP_INSERT))
        else $error("table write outside insert");

    // search window stays ordered and inside the filled part
    a_search_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SRCH) |-> (r_lo <= r_hi) && (r_hi <= r_count))
        else $error("search window out of order");

    // an accepted request always leaves idle
    a_leave_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state != ST_IDLE))
        else $error("request accepted without leaving idle");

    // fill count moves only by a clear or by one for an insert
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |->
            (r_count == '0) || (r_count == CW'($past(r_count) + 1'b1)))
        else $error("fill count jumped");

    // a response goes out only from the response state
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (r_state == ST_RESP) && (n_state == ST_IDLE))
        else $error("response loaded outside response state");

endmodule

### tb/sv/lookup_checker.sv
// response checker for the nearest timestamp lookup: follows the request, response and
// tolerance write channels, keeps its own sorted table and compares every response
// depends on ntl_pkg
`timescale 1ns / 1ps

module lookup_checker
    import ntl_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_ready,
    input  t_req             i_in_req,
    input  logic             i_out_valid,
    input  logic             i_out_ready,
    input  t_rsp             i_out_rsp,
    input  logic             i_cfg_valid,
    input  logic             i_cfg_ready,
    input  logic [TOL_W-1:0] i_cfg_data,
    output int               o_pending,
    output int               o_mismatches
);

    localparam logic [TOL_W-1:0] TOL_AT_RESET = 32'd100000;
    localparam int               DUE_DEPTH    = 8;

    logic [KEY_W-1:0] time_tbl [TABLE_DEPTH];
    logic [TAG_W-1:0] tag_tbl  [TABLE_DEPTH];
    int               held;
    logic [TOL_W-1:0] tolerance;
    // ring of expected responses, oldest at due_rd
    t_rsp             due_rsp [DUE_DEPTH];
    int               due_wr = 0;
    int               due_rd = 0;
    t_rsp             next_due;
    t_rsp             want;
    int               rsp_index = 0;
    int               mismatch_total = 0;

    assign o_mismatches = mismatch_total;

    // applies one request to the table copy and returns the response it should give
    function automatic t_rsp lookup_response(input t_req req);
        t_rsp             rsp;
        int               pos;
        logic [KEY_W-1:0] best_d;
        logic [TAG_W-1:0] best_tag;
        rsp = '0;
        case (req.operation)
            OP_CLEAR: begin
                held = 0;
            end
            OP_INSERT: begin
                if (held >= TABLE_DEPTH) begin
                    rsp.status = STATUS_FULL;
                end else begin
                    // walk down from the top, new entry lands after its equals
                    pos = held;
                    while (pos > 0 && time_tbl[pos-1] > req.key_time) begin
                        time_tbl[pos] = time_tbl[pos-1];
                        tag_tbl[pos]  = tag_tbl[pos-1];
                        pos--;
                    end
                    time_tbl[pos] = req.key_time;
                    tag_tbl[pos]  = req.entry_tag;
                    held++;
                end
            end
            OP_QUERY: begin
                rsp.status = STATUS_NO_MATCH;
                if (held > 0) begin
                    // first entry at or after the query time
                    pos = 0;
                    while (pos < held && time_tbl[pos] < req.key_time) begin
                        pos++;
                    end
                    best_d   = '0;
                    best_tag = '0;
                    if (pos < held) begin
                        best_d   = time_tbl[pos] - req.key_time;
                        best_tag = tag_tbl[pos];
                    end
                    // earlier neighbor only when strictly closer
                    if (pos > 0 && (pos == held || req.key_time - time_tbl[pos-1] < best_d)) begin
                        best_d   = req.key_time - time_tbl[pos-1];
                        best_tag = tag_tbl[pos-1];
                    end
                    if (best_d <= KEY_W'(tolerance)) begin
                        rsp.status         = STATUS_OK;
                        rsp.match_tag      = best_tag;
                        rsp.abs_difference = best_d;
                    end
                end
            end
            default: begin
            end
        endcase
        rsp.entry_count = CNT_W'(held);
        return rsp;
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t ns: response %0d: %s", $time, rsp_index, what);
        mismatch_total++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] exp_val);
        if (got !== exp_val) begin
            report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, exp_val));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            held      = 0;
            tolerance = TOL_AT_RESET;
            due_wr    = 0;
            due_rd    = 0;
            o_pending <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                tolerance = i_cfg_data;
            end
            if (i_in_valid && i_in_ready) begin
                next_due = lookup_response(i_in_req);
                if (due_wr - due_rd >= DUE_DEPTH) begin
                    report_mismatch("more requests outstanding than the block can hold");
                end else begin
                    due_rsp[due_wr % DUE_DEPTH] = next_due;
                    due_wr++;
                end
            end
            if (i_out_valid && i_out_ready) begin
                if (due_wr == due_rd) begin
                    report_mismatch("response with no request outstanding");
                end else begin
                    want = due_rsp[due_rd % DUE_DEPTH];
                    due_rd++;
                    check_field("status", 64'(i_out_rsp.status), 64'(want.status));
                    check_field("match_tag", 64'(i_out_rsp.match_tag), 64'(want.match_tag));
                    check_field("abs_difference", 64'(i_out_rsp.abs_difference),
                                64'(want.abs_difference));
                    check_field("entry_count", 64'(i_out_rsp.entry_count),
                                64'(want.entry_count));
                end
                rsp_index++;
            end
            o_pending <= due_wr - due_rd;
        end
    end

endmodule

### tb/sv/testbench.sv
// top of the nearest timestamp lookup test: clock, reset, request and tolerance
// stimulus, response back-pressure and the final verdict
// depends on ntl_pkg, nearest_timestamp_lookup and lookup_checker
`timescale 1ns / 1ps

module testbench;
    import ntl_pkg::*;

    localparam int               TABLE_DEPTH  = 1024;
    localparam logic [OP_W-1:0]  OP_UNUSED    = 2'd3;
    localparam logic [TOL_W-1:0] TOL_DEFAULT  = 32'd100000;
    localparam logic [TOL_W-1:0] TOL_MAX      = '1;
    localparam logic [KEY_W-1:0] KEY_MAX      = '1;
    localparam logic [TAG_W-1:0] TAG_MAX      = '1;
    localparam int               HOLD_AFTER   = 400;  // requests taken before the long stall
    localparam int               HOLD_CYCLES  = 600;
    localparam int               DRAIN_CYCLES = 60;
    localparam int               KEY_POOL     = 64;   // keys remembered in one episode

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    logic             in_ready;
    t_req             in_req    = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    t_rsp             out_rsp;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [TOL_W-1:0] cfg_data  = '0;

    int               pending;
    int               mismatches;
    int               req_count  = 0;
    int               burst_left = 0;
    logic [TOL_W-1:0] cur_tol    = TOL_DEFAULT;  // steers the stimulus only

    // 12 ns clock
    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    nearest_timestamp_lookup #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_req    (in_req),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_rsp   (out_rsp),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    lookup_checker #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_req     (in_req),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_rsp    (out_rsp),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .o_pending    (pending),
        .o_mismatches (mismatches)
    );

    // accepted requests, used to place the long output stall
    always @(posedge clk) begin
        if (in_valid && in_ready) begin
            req_count <= req_count + 1;
        end
    end

    function automatic logic [KEY_W-1:0] rand_key();
        return KEY_W'({$urandom, $urandom});
    endfunction

    function automatic logic [TAG_W-1:0] rand_tag();
        return TAG_W'($urandom);
    endfunction

    // uniform-ish value in 0..bound
    function automatic longint unsigned rand_upto(input longint unsigned bound);
        longint unsigned v;
        v = {$urandom, $urandom};
        return v % (bound + 1);
    endfunction

    // offers one request and returns at the edge where it is taken; valid stays
    // high so a back-to-back request keeps the channel busy without a bubble
    task automatic send_request(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                                input logic [TAG_W-1:0] tag);
        t_req req;
        req.operation = op;
        req.key_time  = key;
        req.entry_tag = tag;
        if (burst_left == 0) begin
            // new burst, most of the time after an idle gap
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 3) != 0) begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 30)) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_req   <= req;
        @(posedge clk);
        while (!in_ready) begin
            @(posedge clk);
        end
    endtask

    // drop valid and wait until every outstanding request has answered
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) begin
            @(posedge clk);
        end
    endtask

    task automatic write_tolerance(input logic [TOL_W-1:0] value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        cur_tol = value;
    endtask

    // hand-picked requests at the reset tolerance
    task automatic directed_requests();
        send_request(OP_QUERY, 48'd5, '0);                    // empty table
        send_request(OP_INSERT, '0, '0);
        send_request(OP_INSERT, KEY_MAX, TAG_MAX);
        send_request(OP_INSERT, 48'd1000, 16'h1111);
        send_request(OP_INSERT, 48'd1000, 16'h2222);          // equal key goes after
        send_request(OP_INSERT, 48'd3000, 16'hA5A5);
        send_request(OP_QUERY, 48'd1000, '0);                 // exact hit on first of equals
        send_request(OP_QUERY, 48'd2000, '0);                 // tie, later entry wins
        send_request(OP_QUERY, 48'd1999, '0);                 // earlier strictly closer
        send_request(OP_QUERY, 48'd500, '0);                  // tie against key zero
        send_request(OP_QUERY, KEY_MAX, '0);
        send_request(OP_QUERY, 48'h8000_0000_0000, '0);       // far from everything
        send_request(OP_QUERY, 48'd103000, '0);               // difference equals tolerance
        send_request(OP_QUERY, 48'd103001, '0);               // one past tolerance
        send_request(OP_UNUSED, KEY_MAX, TAG_MAX);            // ignored code
        send_request(OP_INSERT, KEY_MAX, 16'h5A5A);
        send_request(OP_QUERY, KEY_MAX - 1, '0);
        send_request(OP_UNUSED, '0, '0);
        send_request(OP_CLEAR, KEY_MAX, TAG_MAX);
        send_request(OP_QUERY, '0, TAG_MAX);                  // empty after clear
        send_request(OP_INSERT, 48'h5555_5555_5555, 16'h0001);
        send_request(OP_QUERY, '0, '0);
        send_request(OP_INSERT, 48'hAAAA_AAAA_AAAA, 16'h8000);
        send_request(OP_QUERY, 48'h8000_0000_0000, '0);
    endtask

    // clear, then a mix of inserts around one base time and queries near the
    // inserted times, with some noise requests
    task automatic run_episode(input int n_items);
        logic [KEY_W-1:0] keys [KEY_POOL];
        int               n_keys;
        logic [KEY_W-1:0] base;
        logic [KEY_W-1:0] k;
        longint unsigned  spread;
        int               pick;
        n_keys = 0;
        spread = (cur_tol == '0) ? 64'd3 : 64'(cur_tol) + 64'(cur_tol) / 2;
        case ($urandom_range(0, 7))
            0: begin
                base = '0;
            end
            1: begin
                base = KEY_MAX - KEY_W'(spread * 8);
            end
            default: begin
                base = rand_key();
            end
        endcase
        send_request(OP_CLEAR, rand_key(), rand_tag());
        repeat (n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 35 || (n_keys == 0 && pick < 80)) begin
                if (n_keys > 0 && $urandom_range(0, 5) == 0) begin
                    k = keys[$urandom_range(0, n_keys - 1)];
                end else begin
                    k = base + KEY_W'(rand_upto(spread * 6));
                end
                if (n_keys < KEY_POOL) begin
                    keys[n_keys] = k;
                    n_keys++;
                end
                send_request(OP_INSERT, k, rand_tag());
            end else if (pick < 80) begin
                k = keys[$urandom_range(0, n_keys - 1)];
                pick = $urandom_range(0, 4);
                if (pick == 1 || pick == 2) begin
                    k = k + KEY_W'(rand_upto(spread));
                end else if (pick > 2) begin
                    k = k - KEY_W'(rand_upto(spread));
                end
                send_request(OP_QUERY, k, rand_tag());
            end else if (pick < 87) begin
                send_request(OP_QUERY, rand_key(), rand_tag());
            end else if (pick < 91) begin
                send_request(OP_UNUSED, rand_key(), rand_tag());
            end else if (pick < 95) begin
                n_keys = 0;
                send_request(OP_CLEAR, rand_key(), rand_tag());
            end else begin
                k = rand_key();
                if (n_keys < KEY_POOL) begin
                    keys[n_keys] = k;
                    n_keys++;
                end
                send_request(OP_INSERT, k, rand_tag());
            end
        end
    endtask

    task automatic run_random(input int n_items);
        int done;
        int len;
        done = 0;
        while (done < n_items) begin
            len = $urandom_range(5, 60);
            run_episode(len);
            done += len + 1;
        end
    endtask

    // fills the whole table, mostly in ascending order so inserts stay cheap,
    // then probes it while full
    task automatic fill_table();
        logic [KEY_W-1:0] k;
        longint unsigned  step;
        step = 64'(cur_tol) * 2;
        k = KEY_W'(rand_upto(64'h0000_00FF_FFFF_FFFF));
        send_request(OP_CLEAR, rand_key(), rand_tag());
        for (int n = 0; n < TABLE_DEPTH; n++) begin
            if ($urandom_range(0, 127) == 0) begin
                // lands low in the table, so most entries have to move
                send_request(OP_INSERT, KEY_W'(rand_upto(64'(k))), rand_tag());
            end else begin
                k = k + KEY_W'(rand_upto(step));
                send_request(OP_INSERT, k, rand_tag());
            end
            if ($urandom_range(0, 9) == 0) begin
                send_request(OP_QUERY, k - KEY_W'(rand_upto(step)), rand_tag());
            end
        end
        // full table: inserts are refused, lookups still work
        send_request(OP_INSERT, k, rand_tag());
        send_request(OP_INSERT, KEY_MAX, TAG_MAX);
        send_request(OP_INSERT, '0, '0);
        send_request(OP_QUERY, '0, rand_tag());
        send_request(OP_QUERY, KEY_MAX, rand_tag());
        repeat (8) begin
            send_request(OP_QUERY, k - KEY_W'(rand_upto(step * 600)), rand_tag());
        end
        send_request(OP_UNUSED, rand_key(), rand_tag());
        send_request(OP_CLEAR, rand_key(), rand_tag());
        send_request(OP_QUERY, k, rand_tag());
    endtask

    // match boundary at the widest tolerance
    task automatic wide_tolerance_edges();
        logic [KEY_W-1:0] k;
        k = rand_key() >> 1;
        send_request(OP_CLEAR, '0, '0);
        send_request(OP_INSERT, k, rand_tag());
        send_request(OP_QUERY, k + 48'h0000_FFFF_FFFF, rand_tag());
        send_request(OP_QUERY, k + 48'h0001_0000_0000, rand_tag());
    endtask

    // response side: stall patterns in segments, plus one long hold while the
    // request side keeps pushing so the block backs up to its input
    initial begin
        int  seg_len;
        int  mode;
        int  tick;
        bit  held_off;
        tick     = 0;
        held_off = 1'b0;
        while (!rst_n) begin
            @(posedge clk);
        end
        forever begin
            if (!held_off && req_count >= HOLD_AFTER) begin
                held_off = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            mode    = $urandom_range(0, 3);
            seg_len = $urandom_range(10, 150);
            repeat (seg_len) begin
                case (mode)
                    0: begin
                        out_ready <= 1'b1;
                    end
                    1: begin
                        out_ready <= ($urandom_range(0, 1) == 1);
                    end
                    2: begin
                        out_ready <= ($urandom_range(0, 4) == 0);
                    end
                    default: begin
                        out_ready <= (tick % 4 != 3);
                    end
                endcase
                tick++;
                @(posedge clk);
            end
        end
    end

    // request side and verdict
    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_requests();

        write_tolerance('0);
        run_random(120);

        write_tolerance(TOL_W'($urandom_range(1000, 1000000)));
        fill_table();

        write_tolerance(TOL_MAX);
        wide_tolerance_edges();
        run_random(120);

        write_tolerance(TOL_W'($urandom));
        run_random(120);

        write_tolerance(TOL_W'($urandom_range(1, 5000)));
        run_random(120);

        write_tolerance(TOL_DEFAULT);
        run_random(120);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // watchdog, several times the slowest legal run
    initial begin
        #100_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
